### rtl/core/lrfr_pkg.sv
// shared constants, register codes and the sine table of the led ring frame renderer
`default_nettype none

package lrfr_pkg;

    // ring size and derived widths
    localparam int PIXEL_COUNT = 8;
    localparam int PIX_IDX_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(PIXEL_COUNT - 1);

    // register indexes of the configuration port
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd1;
    localparam logic [1:0] REG_COLOUR     = 2'd2;

    // display modes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_SOLID   = 3'd1;
    localparam logic [2:0] MODE_STATUS  = 3'd2;
    localparam logic [2:0] MODE_BREATHE = 3'd3;

    // reset values of the registers
    localparam logic [2:0]  MODE_RESET       = MODE_OFF;
    localparam logic [6:0]  BRIGHTNESS_RESET = 7'd100;
    localparam logic [23:0] COLOUR_RESET     = 24'hFFFFFF;

    // sweep: head = (t mod (120 * count)) / 120
    localparam logic [12:0] SWEEP_MOD   = 13'(120 * PIXEL_COUNT);
    localparam logic [25:0] SWEEP_RECIP = 26'((64'd1 << 32) / (120 * PIXEL_COUNT));
    // r / 120 as (r * 8739) >> 20, exact for r below 10000
    localparam logic [13:0] DIV120_MUL  = 14'd8739;

    // breathe: phase step per ms and the Q16 factor terms
    localparam logic [12:0] PHASE_STEP = 13'd4272;
    localparam logic signed [31:0] K_BASE  = 32'sd1234796544;
    localparam logic signed [31:0] K_SWING = 32'sd27853;

    // scaling: full brightness, dim divisor and divide by 100
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [7:0]  DIV5_MUL   = 8'd205;
    localparam logic [12:0] DIV100_MUL = 13'd5243;

    // quarter wave of the sine in Q1.15
    function automatic logic [14:0] quarter_sine(input logic [6:0] j);
        logic [14:0] v;
        case (j)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd804;   7'd2:  v = 15'd1608;
            7'd3:  v = 15'd2410;  7'd4:  v = 15'd3212;  7'd5:  v = 15'd4011;
            7'd6:  v = 15'd4808;  7'd7:  v = 15'd5602;  7'd8:  v = 15'd6393;
            7'd9:  v = 15'd7179;  7'd10: v = 15'd7962;  7'd11: v = 15'd8739;
            7'd12: v = 15'd9512;  7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
            7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13279;
            7'd18: v = 15'd14010; 7'd19: v = 15'd14733; 7'd20: v = 15'd15446;
            7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
            7'd24: v = 15'd18204; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
            7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
            7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
            7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
            7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
            7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
            7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
            7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
            7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
            7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
            7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
            7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
            7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
            7'd63: v = 15'd32757; 7'd64: v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // full-wave sine by quadrant symmetry
    function automatic logic signed [15:0] sine_q15(input logic [7:0] idx);
        logic [6:0]  j;
        logic [6:0]  jr;
        logic [14:0] mag;
        j   = {1'b0, idx[5:0]};
        jr  = 7'd64 - j;
        mag = idx[6] ? quarter_sine(jr) : quarter_sine(j);
        return idx[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

`default_nettype wire

### rtl/core/led_ring_frame_renderer_unit.sv
// led ring frame renderer: frame math pipeline, pixel sequencer and pixel scaling pipeline
//
// Usage: each transaction on the frame channel (frame_valid, frame_stall, time_ms) asks
// for one frame. The block emits PIXEL_COUNT transactions on the pixel channel
// (pixel_valid, pixel_stall, pixel_index, green/red/blue levels, frame_last), pixel 0
// first, frame_last on the final pixel. Registers are written on the cfg channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high and writes
// must happen only while no frame is in flight.
// Pipeline: five frame stages (input, sweep reciprocal and phase multiply, remainder and
// sine lookup, correction and breathe factor, head and breathe percent) feed three pixel
// stages. Throughput: one pixel per cycle while pixel_stall does not hold the pixel
// stages back; the pixel sequencer walking the ring sets that rate, and a frame leaves
// it on its final pixel. Frames queue in the frame stages.
// Reset: registers return to mode off, brightness 100, colour white; the pipeline
// empties. A stall on the pixel channel holds the shown pixel and backs up the
// stages one by one; frame_stall rises once the input stage is full.
`default_nettype none

module led_ring_frame_renderer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // frame requests
    input  wire logic        frame_valid,
    output logic             frame_stall,
    input  wire logic [31:0] time_ms,
    // pixel results
    output logic             pixel_valid,
    input  wire logic        pixel_stall,
    output logic [5:0]       pixel_index,
    output logic [7:0]       green_level,
    output logic [7:0]       red_level,
    output logic [7:0]       blue_level,
    output logic             frame_last,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int IW = lrfr_pkg::PIX_IDX_W;

    // configuration registers
    logic [2:0]  display_mode_reg;
    logic [6:0]  brightness_pct_reg;
    logic [23:0] base_colour_reg;

    // frame stage valids and payload
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic [31:0] s1_time_reg, s2_time_reg;
    logic [25:0] s2_quot_reg;
    logic [7:0]  s2_phase_reg;
    logic [13:0] s3_rem_raw_reg;
    logic signed [15:0] s3_sine_reg;
    logic [12:0] s4_rem_reg;
    logic [15:0] s4_factor_reg;
    logic [IW-1:0] s5_head_reg;
    logic [6:0]  s5_breath_reg;

    // pixel sequencer and pixel stages
    logic [IW-1:0] cnt_reg, cnt_next;
    logic        e_valid_reg, m_valid_reg, o_valid_reg;
    logic [IW-1:0] e_idx_reg, m_idx_reg, o_idx_reg;
    logic        e_last_reg, m_last_reg, o_last_reg;
    logic [6:0]  e_pct_reg;
    logic [14:0] m_green_reg, m_red_reg, m_blue_reg;
    logic [7:0]  o_green_reg, o_red_reg, o_blue_reg;

    // stage readiness
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
    logic e_ready, m_ready, o_ready;
    logic pix_issue, pix_last;

    // combinational datapath
    logic [57:0] quot_prod;
    logic [36:0] phase_prod;
    logic [38:0] quot_mul;
    logic [31:0] rem_diff;
    logic [12:0] rem_corr;
    logic signed [31:0] factor_sum;
    logic [26:0] head_prod;
    logic [22:0] breath_prod;
    logic [14:0] dim_prod;
    logic [6:0]  dim_pct;
    logic [6:0]  pix_pct;
    logic [6:0]  eff_pct;
    logic [27:0] green_div, red_div, blue_div;

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg   <= lrfr_pkg::MODE_RESET;
            brightness_pct_reg <= lrfr_pkg::BRIGHTNESS_RESET;
            base_colour_reg    <= lrfr_pkg::COLOUR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrfr_pkg::REG_MODE:       display_mode_reg   <= cfg_data[2:0];
                lrfr_pkg::REG_BRIGHTNESS: brightness_pct_reg <= cfg_data[6:0];
                lrfr_pkg::REG_COLOUR:     base_colour_reg    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // backpressure chain from the pixel output back to the frame input
    assign o_ready   = !o_valid_reg || !pixel_stall;
    assign m_ready   = !m_valid_reg || o_ready;
    assign e_ready   = !e_valid_reg || m_ready;
    assign pix_last  = (cnt_reg == lrfr_pkg::LAST_IDX);
    assign pix_issue = s5_valid_reg && e_ready;
    assign s5_ready  = !s5_valid_reg || (pix_issue && pix_last);
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign frame_stall = !s1_ready;

    assign cnt_next = pix_last ? '0 : cnt_reg + 1'b1;

    // valid bits and pixel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= frame_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
            if (e_ready)  e_valid_reg  <= s5_valid_reg;
            if (m_ready)  m_valid_reg  <= e_valid_reg;
            if (o_ready)  o_valid_reg  <= m_valid_reg;
            if (pix_issue) cnt_reg <= cnt_next;
        end
    end

    // frame math: sweep quotient estimate, remainder, correction, head; breathe phase, factor and percent
    always_comb
    begin
        quot_prod  = 58'(s1_time_reg) * 58'(lrfr_pkg::SWEEP_RECIP);
        phase_prod = 37'(s1_time_reg[23:0]) * 37'(lrfr_pkg::PHASE_STEP);
        quot_mul   = 39'(s2_quot_reg) * 39'(lrfr_pkg::SWEEP_MOD);
        rem_diff   = s2_time_reg - quot_mul[31:0];
        rem_corr   = (s3_rem_raw_reg >= 14'(lrfr_pkg::SWEEP_MOD))
                   ? 13'(s3_rem_raw_reg - 14'(lrfr_pkg::SWEEP_MOD))
                   : s3_rem_raw_reg[12:0];
        factor_sum = lrfr_pkg::K_BASE + 32'(s3_sine_reg) * lrfr_pkg::K_SWING;
        head_prod  = 27'(s4_rem_reg) * 27'(lrfr_pkg::DIV120_MUL);
        breath_prod = 23'(brightness_pct_reg) * 23'(s4_factor_reg);
    end

    // frame stage payload
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_time_reg <= time_ms;
        end
        if (s2_ready)
        begin
            s2_time_reg  <= s1_time_reg;
            s2_quot_reg  <= quot_prod[57:32];
            s2_phase_reg <= phase_prod[23:16];
        end
        if (s3_ready)
        begin
            s3_rem_raw_reg <= rem_diff[13:0];
            s3_sine_reg    <= lrfr_pkg::sine_q15(s2_phase_reg);
        end
        if (s4_ready)
        begin
            s4_rem_reg    <= rem_corr;
            s4_factor_reg <= factor_sum[30:15];
        end
        if (s5_ready)
        begin
            s5_head_reg   <= IW'(head_prod[26:20]);
            s5_breath_reg <= breath_prod[22:16];
        end
    end

    // per-pixel brightness by mode
    always_comb
    begin
        dim_prod = 15'(brightness_pct_reg) * 15'(lrfr_pkg::DIV5_MUL);
        dim_pct  = {2'b00, dim_prod[14:10]};
        case (display_mode_reg)
            lrfr_pkg::MODE_SOLID:   pix_pct = brightness_pct_reg;
            lrfr_pkg::MODE_STATUS:  pix_pct = (cnt_reg == s5_head_reg) ? brightness_pct_reg
                                                                       : dim_pct;
            lrfr_pkg::MODE_BREATHE: pix_pct = s5_breath_reg;
            default:                pix_pct = 7'd0;
        endcase
    end

    // scaling: full brightness clamps to 100 so that v*100/100 passes v
    always_comb
    begin
        eff_pct   = (e_pct_reg >= lrfr_pkg::PCT_FULL) ? lrfr_pkg::PCT_FULL : e_pct_reg;
        green_div = 28'(m_green_reg) * 28'(lrfr_pkg::DIV100_MUL);
        red_div   = 28'(m_red_reg) * 28'(lrfr_pkg::DIV100_MUL);
        blue_div  = 28'(m_blue_reg) * 28'(lrfr_pkg::DIV100_MUL);
    end

    // pixel stage payload
    always_ff @(posedge clk)
    begin
        if (e_ready)
        begin
            e_idx_reg  <= cnt_reg;
            e_last_reg <= pix_last;
            e_pct_reg  <= pix_pct;
        end
        if (m_ready)
        begin
            m_idx_reg   <= e_idx_reg;
            m_last_reg  <= e_last_reg;
            m_green_reg <= 15'(base_colour_reg[15:8]) * 15'(eff_pct);
            m_red_reg   <= 15'(base_colour_reg[23:16]) * 15'(eff_pct);
            m_blue_reg  <= 15'(base_colour_reg[7:0]) * 15'(eff_pct);
        end
        if (o_ready)
        begin
            o_idx_reg   <= m_idx_reg;
            o_last_reg  <= m_last_reg;
            o_green_reg <= green_div[26:19];
            o_red_reg   <= red_div[26:19];
            o_blue_reg  <= blue_div[26:19];
        end
    end

    // outputs
    assign pixel_valid = o_valid_reg;
    assign pixel_index = 6'(o_idx_reg);
    assign green_level = o_green_reg;
    assign red_level   = o_red_reg;
    assign blue_level  = o_blue_reg;
    assign frame_last  = o_last_reg;

    // checks
    a_last_on_final_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && frame_last |-> o_idx_reg == lrfr_pkg::LAST_IDX)
        else $error("frame_last on a pixel other than the final one");

    a_counter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lrfr_pkg::LAST_IDX)
        else $error("pixel counter beyond the ring");

    a_frame_retires_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s5_valid_reg) |-> $past(pix_issue && pix_last))
        else $error("frame left the sequencer before its final pixel");

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> s4_rem_reg < lrfr_pkg::SWEEP_MOD)
        else $error("sweep remainder not reduced");

endmodule

`default_nettype wire

### tb/lrfr_pixel_checker.sv
// pixel checker for the led ring frame renderer: predicts each frame and compares every pixel
`default_nettype none

module lrfr_pixel_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        frame_valid,
    input  wire logic        frame_stall,
    input  wire logic [31:0] time_ms,
    input  wire logic        pixel_valid,
    input  wire logic        pixel_stall,
    input  wire logic [5:0]  pixel_index,
    input  wire logic [7:0]  green_level,
    input  wire logic [7:0]  red_level,
    input  wire logic [7:0]  blue_level,
    input  wire logic        frame_last,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               mismatch_count,
    output int               pixels_due
);

    // frame math constants
    localparam int unsigned SWEEP_MS     = 120;
    localparam int unsigned PHASE_STEP_T = 4272;
    localparam longint      K_OFFSET     = 37683;
    localparam longint      K_SWING_T    = 27853;
    localparam int unsigned DIM_DIV      = 5;
    localparam int unsigned PCT_MAX      = 100;
    localparam int          MAX_PRINTED  = 40;

    // quarter wave of the sine, Q1.15
    localparam int QUARTER_WAVE [0:64] = '{
            0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
         6393,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14733, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
        23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    typedef struct packed {
        logic [5:0] index;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last;
    } ring_pixel_t;

    // register copies
    logic [2:0]  mode_q;
    logic [6:0]  pct_q;
    logic [23:0] colour_q;

    ring_pixel_t pixels_owed [$];

    // one colour byte at a brightness percent
    function automatic logic [7:0] scale_level(input logic [7:0] v, input int unsigned pct);
        if (pct == 0)
            return 8'd0;
        if (pct >= PCT_MAX)
            return v;
        return 8'((v * pct) / PCT_MAX);
    endfunction

    // breathe percent for a time stamp
    function automatic int unsigned breathe_pct(input logic [31:0] t);
        logic [31:0] phase;
        logic [7:0]  sidx;
        logic [5:0]  j;
        longint      mag;
        longint      sum;
        phase = t * PHASE_STEP_T;
        sidx  = phase[23:16];
        j     = sidx[5:0];
        mag   = sidx[6] ? QUARTER_WAVE[64 - j] : QUARTER_WAVE[j];
        if (sidx[7])
            mag = -mag;
        sum = K_OFFSET * 32768 + K_SWING_T * mag;
        return int'((longint'(pct_q) * (sum >>> 15)) >>> 16);
    endfunction

    // queue up the pixels of one frame
    task automatic render_frame(input logic [31:0] t);
        int unsigned head;
        int unsigned bp;
        int unsigned p;
        ring_pixel_t px;
        head = (t / SWEEP_MS) % lrfr_pkg::PIXEL_COUNT;
        bp   = breathe_pct(t);
        for (int i = 0; i < lrfr_pkg::PIXEL_COUNT; i++)
        begin
            case (mode_q)
                lrfr_pkg::MODE_SOLID:   p = pct_q;
                lrfr_pkg::MODE_STATUS:  p = (i == head) ? pct_q : pct_q / DIM_DIV;
                lrfr_pkg::MODE_BREATHE: p = bp;
                default:                p = 0;
            endcase
            px.index = 6'(i);
            px.green = scale_level(colour_q[15:8], p);
            px.red   = scale_level(colour_q[23:16], p);
            px.blue  = scale_level(colour_q[7:0], p);
            px.last  = (i == lrfr_pkg::PIXEL_COUNT - 1);
            pixels_owed.push_back(px);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        ring_pixel_t want;
        if (!rst_n)
        begin
            mode_q   <= lrfr_pkg::MODE_RESET;
            pct_q    <= lrfr_pkg::BRIGHTNESS_RESET;
            colour_q <= lrfr_pkg::COLOUR_RESET;
            pixels_owed.delete();
            pixels_due <= 0;
            mismatch_count = 0;
        end
        else
        begin
            // pixel transaction against the oldest owed pixel
            if (pixel_valid && !pixel_stall)
            begin
                if (pixels_owed.size() == 0)
                    report_mismatch("unexpected pixel, index", pixel_index, -1);
                else
                begin
                    want = pixels_owed.pop_front();
                    if (pixel_index !== want.index)
                        report_mismatch("pixel_index", pixel_index, want.index);
                    if (green_level !== want.green)
                        report_mismatch("green_level", green_level, want.green);
                    if (red_level !== want.red)
                        report_mismatch("red_level", red_level, want.red);
                    if (blue_level !== want.blue)
                        report_mismatch("blue_level", blue_level, want.blue);
                    if (frame_last !== want.last)
                        report_mismatch("frame_last", frame_last, want.last);
                end
            end
            // frame transaction
            if (frame_valid && !frame_stall)
                render_frame(time_ms);
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lrfr_pkg::REG_MODE:       mode_q   <= cfg_data[2:0];
                    lrfr_pkg::REG_BRIGHTNESS: pct_q    <= cfg_data[6:0];
                    lrfr_pkg::REG_COLOUR:     colour_q <= cfg_data;
                    default:                  ;
                endcase
            end
            pixels_due <= pixels_owed.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_led_ring_frame_renderer_unit.sv
// stimulus, clocking and verdict for the led ring frame renderer testbench
`default_nettype none

module tb_led_ring_frame_renderer_unit;

    localparam int          SETTLE_CYCLES  = 12;
    localparam int          LONG_HOLD      = 150;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_ITEMS   = 230;
    localparam logic [1:0]  REG_SPARE      = 2'd3;

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_BURSTY = 2;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    logic [31:0] time_ms     = '0;
    logic        pixel_valid;
    logic        pixel_stall = 1'b0;
    logic [5:0]  pixel_index;
    logic [7:0]  green_level;
    logic [7:0]  red_level;
    logic [7:0]  blue_level;
    logic        frame_last;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = '0;
    logic [23:0] cfg_data    = '0;

    int mismatch_count;
    int pixels_due;
    int items_sent    = 0;
    int stall_mode    = STALL_RANDOM;
    int long_hold_req = 0;
    int quiet_cycles  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    led_ring_frame_renderer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .time_ms     (time_ms),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_index (pixel_index),
        .green_level (green_level),
        .red_level   (red_level),
        .blue_level  (blue_level),
        .frame_last  (frame_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    lrfr_pixel_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .time_ms        (time_ms),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel_index    (pixel_index),
        .green_level    (green_level),
        .red_level      (red_level),
        .blue_level     (blue_level),
        .frame_last     (frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_due     (pixels_due)
    );

    // watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_valid && !frame_stall) || (pixel_valid && !pixel_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_led_ring_frame_renderer_unit: errors");
                $finish;
            end
        end
    end

    // receiver stall pattern, with long holds on request
    initial
    begin
        int hold_left;
        int holds_served;
        int run_left;
        logic run_level;
        hold_left    = 0;
        holds_served = 0;
        run_left     = 0;
        run_level    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_stall <= 1'b1;
            end
            else if (long_hold_req > holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
                pixel_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:   pixel_stall <= 1'b0;
                    STALL_RANDOM: pixel_stall <= ($urandom_range(0, 99) < 35);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_level = ~run_level;
                            run_left  = $urandom_range(1, 8);
                        end
                        run_left--;
                        pixel_stall <= run_level;
                    end
                endcase
            end
        end
    end

    // offer one frame request and hold it until taken
    task automatic send_frame(input logic [31:0] t);
        frame_valid <= 1'b1;
        time_ms     <= t;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic sender_gap(input int cycles);
        frame_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop offering and wait for every owed pixel, then for the pipeline to settle
    task automatic wait_drained();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (pixels_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // idle the block, then program all three registers
    task automatic set_config(input logic [2:0] mode, input logic [6:0] pct,
                              input logic [23:0] colour);
        wait_drained();
        cfg_write(lrfr_pkg::REG_MODE, {21'($urandom), mode});
        cfg_write(lrfr_pkg::REG_BRIGHTNESS, {17'($urandom), pct});
        cfg_write(lrfr_pkg::REG_COLOUR, colour);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // time stamps: wide random, small, near wrap, around sweep steps
    function automatic logic [31:0] pick_time();
        logic [31:0] m;
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 2000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 500);
            2:
            begin
                m = $urandom_range(0, 30000000) * 120;
                return m + $urandom_range(0, 2) - 1;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        case ($urandom_range(0, 9))
            0, 1:    return lrfr_pkg::MODE_SOLID;
            2, 3:    return lrfr_pkg::MODE_STATUS;
            4, 5, 6: return lrfr_pkg::MODE_BREATHE;
            7:       return lrfr_pkg::MODE_OFF;
            8:       return 3'($urandom_range(4, 7));
            default: return 3'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [6:0] pick_pct();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return lrfr_pkg::PCT_FULL;
            2:       return 7'd127;
            3:       return 7'($urandom_range(101, 127));
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic logic [23:0] pick_colour();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // random bursts with random gaps
    task automatic send_bursts(input int count, input int gap_max);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 8);
            if (burst > left)
                burst = left;
            for (int i = 0; i < burst; i++)
                send_frame(pick_time());
            left -= burst;
            if (gap_max > 0)
                sender_gap($urandom_range(1, gap_max));
        end
    endtask

    initial
    begin
        int phase_no;
        int random_start;
        int count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: mode off
        send_frame(32'h0000_0000);
        send_frame(32'hFFFF_FFFF);
        // solid at full, zero, above hundred and just under full
        set_config(lrfr_pkg::MODE_SOLID, lrfr_pkg::PCT_FULL, 24'hFFFFFF);
        send_frame(32'd0);
        set_config(lrfr_pkg::MODE_SOLID, 7'd0, 24'hFFFFFF);
        send_frame(32'd5);
        set_config(lrfr_pkg::MODE_SOLID, 7'd127, 24'h123456);
        send_frame(32'd1);
        set_config(lrfr_pkg::MODE_SOLID, 7'd99, 24'hFFFFFF);
        send_frame(32'hAAAA_5555);
        // status sweep: head steps, ring wrap, time wrap, dim to zero
        set_config(lrfr_pkg::MODE_STATUS, lrfr_pkg::PCT_FULL, 24'hFF8001);
        send_frame(32'd0);
        send_frame(32'd119);
        send_frame(32'd120);
        send_frame(32'd959);
        send_frame(32'd960);
        send_frame(32'hFFFF_FFFF);
        set_config(lrfr_pkg::MODE_STATUS, 7'd4, 24'hFFFFFF);
        send_frame(32'd250);
        // breathe across the four quadrants of the sine and above hundred
        set_config(lrfr_pkg::MODE_BREATHE, lrfr_pkg::PCT_FULL, 24'hFFFFFF);
        send_frame(32'd0);
        send_frame(32'd982);
        send_frame(32'd1964);
        send_frame(32'd2946);
        set_config(lrfr_pkg::MODE_BREATHE, 7'd127, 24'h5A0FF0);
        send_frame(32'hFFFF_FFFF);
        // unknown modes render dark; a spare register index is ignored
        set_config(3'd7, lrfr_pkg::PCT_FULL, 24'hFFFFFF);
        send_frame(32'd1234);
        set_config(3'd4, lrfr_pkg::PCT_FULL, 24'hFFFFFF);
        cfg_write(REG_SPARE, 24'($urandom));
        cfg_valid <= 1'b0;
        send_frame(32'h8000_0000);

        // random phases
        random_start = items_sent;
        phase_no     = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            set_config(pick_mode(), pick_pct(), pick_colour());
            stall_mode = $urandom_range(STALL_NONE, STALL_BURSTY);
            count      = $urandom_range(10, 30);
            if (phase_no == 3)
            begin
                // long receiver hold while frames keep coming back to back
                long_hold_req++;
                for (int i = 0; i < 30; i++)
                    send_frame(pick_time());
            end
            else if (phase_no == 5)
            begin
                send_bursts(count / 2, 6);
                wait_drained();
                send_bursts(count - count / 2, 6);
            end
            else
                send_bursts(count, ($urandom_range(0, 2) == 0) ? 0 : 20);
            phase_no++;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("tb_led_ring_frame_renderer_unit: clean");
        else
            $display("tb_led_ring_frame_renderer_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire

### led_ring_frame_renderer_unit.f
rtl/core/lrfr_pkg.sv
rtl/core/led_ring_frame_renderer_unit.sv
tb/lrfr_pixel_checker.sv
tb/tb_led_ring_frame_renderer_unit.sv
